// ===== rtl/keypad_history_event_queue_macros.svh =====
// Assertion macros for the keypad history event queue.
// Uses clk_i and rst_ni of the module that includes it; no other dependencies.
`ifndef KEYPAD_HISTORY_EVENT_QUEUE_MACROS_SVH
`define KEYPAD_HISTORY_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define KHQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define KHQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/khq_pkg.sv =====
// Shared types and constants for the keypad history event queue.
// No dependencies.
`timescale 1ns / 1ps

package khq_pkg;

  // Column count and row field width are fixed by the sample format
  localparam int unsigned COL_COUNT = 4;
  localparam int unsigned COL_BITS  = 2;
  localparam int unsigned ROW_FIELD = 4;
  localparam int unsigned CODE_BITS = 8;

  localparam logic [CODE_BITS-1:0] MARK_BIT = 8'h80;

  // Key characters, "DCBA#9630852*741"
  localparam logic [CODE_BITS-1:0] CHAR_MAP [16] = '{
    8'h44, 8'h43, 8'h42, 8'h41, 8'h23, 8'h39, 8'h36, 8'h33,
    8'h30, 8'h38, 8'h35, 8'h32, 8'h2A, 8'h37, 8'h34, 8'h31
  };

  typedef enum logic [0:0] {
    OP_SCAN = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [COL_BITS-1:0] column;
    logic [ROW_FIELD-1:0] row_bits;
  } cmd_t;

endpackage

// ===== rtl/khq_if.sv =====
// Channel interfaces: request beats in, event beats out.
// Depends on nothing but the fixed field widths.
`timescale 1ns / 1ps

interface khq_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] column;
  logic [3:0] row_bits;

  modport source (output valid, output kind, output column, output row_bits, input ready);
  modport sink   (input valid, input kind, input column, input row_bits, output ready);
endinterface

interface khq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] event_code;
  logic       queue_empty;

  modport source (output valid, output event_code, output queue_empty, input ready);
  modport sink   (input valid, input event_code, input queue_empty, output ready);
endinterface

// ===== rtl/khq_front.sv =====
// Front end: accepts request beats and classifies them into commands.
// Depends on khq_pkg and khq_in_if.
`timescale 1ns / 1ps

module khq_front #(
  parameter int unsigned ROW_COUNT = 4,
  parameter int unsigned KEY_COUNT = 16
) (
  khq_in_if.sink               req_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output khq_pkg::cmd_t        cmd_o,
  output logic [ROW_COUNT-1:0] key_ok_o
);
  import khq_pkg::*;

  // Pass the handshake through to the command queue
  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;

  // Decode the operation and copy the sample
  always_comb begin
    cmd_o.op       = req_i.kind ? OP_POP : OP_SCAN;
    cmd_o.column   = req_i.column;
    cmd_o.row_bits = req_i.row_bits;
  end

  // Flag rows whose key index falls inside the key count
  always_comb begin
    for (int unsigned r = 0; r < ROW_COUNT; r++) begin
      key_ok_o[r] = (32'(req_i.column) * ROW_COUNT + r) < KEY_COUNT;
    end
  end

endmodule

// ===== rtl/khq_cmd_fifo.sv =====
// Two-entry command queue between the front and back ends.
// Generic payload; no package dependencies.
`timescale 1ns / 1ps

module khq_cmd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i  ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/khq_back.sv =====
// Back end: key histories, press detection, event slots and the result register.
// Depends on khq_pkg and khq_out_if.
`timescale 1ns / 1ps

module khq_back #(
  parameter int unsigned ROW_COUNT    = 4,
  parameter int unsigned HISTORY_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 press_mark_we_i,
  input  logic                 press_mark_i,
  input  logic                 cmd_valid_i,
  input  khq_pkg::cmd_t        cmd_i,
  input  logic [ROW_COUNT-1:0] key_ok_i,
  output logic                 cmd_ready_o,
  khq_out_if.source            rsp_o
);
  import khq_pkg::*;

  localparam logic [HISTORY_BITS-1:0] PRESS_PATTERN = {{(HISTORY_BITS-1){1'b0}}, 1'b1};

  logic [HISTORY_BITS-1:0] hist_q [COL_COUNT][ROW_COUNT];
  logic [HISTORY_BITS-1:0] hist_d [COL_COUNT][ROW_COUNT];
  logic [CODE_BITS-1:0]    slot_q [2];
  logic [CODE_BITS-1:0]    slot_d [2];
  logic                    wr_q, wr_d;
  logic                    rd_q, rd_d;
  logic                    mark_q;
  logic                    out_valid_q, out_valid_d;
  logic [CODE_BITS-1:0]    out_code_q, out_code_d;
  logic                    out_empty_q, out_empty_d;
  logic                    fire;
  logic [ROW_FIELD+ROW_COUNT-1:0] rows_wide;

  // Take a scan at once, a pop only when the result register frees up
  assign cmd_ready_o = (cmd_i.op == OP_SCAN) || !out_valid_q || rsp_o.ready;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign rows_wide   = {{ROW_COUNT{1'b0}}, cmd_i.row_bits};

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.event_code  = out_code_q;
  assign rsp_o.queue_empty = out_empty_q;

  // Shift histories, push presses in row order, or pop one slot
  always_comb begin
    logic [HISTORY_BITS-1:0] h;
    logic [3:0]              key;
    logic [CODE_BITS-1:0]    code;
    hist_d      = hist_q;
    slot_d      = slot_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    out_code_d  = out_code_q;
    out_empty_d = out_empty_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    h           = '0;
    key         = '0;
    code        = '0;
    if (fire) begin
      unique case (cmd_i.op)
        OP_SCAN: begin
          for (int unsigned r = 0; r < ROW_COUNT; r++) begin
            h   = {hist_q[cmd_i.column][r][HISTORY_BITS-2:0], rows_wide[r]};
            key = 4'(32'(cmd_i.column) * ROW_COUNT + r);
            code = CHAR_MAP[key] | (mark_q ? MARK_BIT : '0);
            if (key_ok_i[r]) begin
              hist_d[cmd_i.column][r] = h;
              if (h == PRESS_PATTERN) begin
                slot_d[wr_d] = code;
                wr_d         = ~wr_d;
              end
            end
          end
        end
        OP_POP: begin
          out_valid_d = 1'b1;
          out_code_d  = slot_q[rd_q];
          out_empty_d = slot_q[rd_q] == '0;
          if (slot_q[rd_q] != '0) begin
            slot_d[rd_q] = '0;
            rd_d         = ~rd_q;
          end
        end
        default: begin
          out_valid_d = out_valid_q && !rsp_o.ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '{default: '0};
      slot_q      <= '{default: '0};
      wr_q        <= 1'b0;
      rd_q        <= 1'b0;
      mark_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      hist_q      <= hist_d;
      slot_q      <= slot_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
      if (press_mark_we_i) begin
        mark_q <= press_mark_i;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    out_code_q  <= out_code_d;
    out_empty_q <= out_empty_d;
  end

endmodule

// ===== rtl/keypad_history_event_queue.sv =====
// Keypad scanner with per-key shift-history debounce and two-slot event queue.
// Use: req_i carries column scan samples (kind 0) and pop requests (kind 1) as
//   valid/ready beats; rsp_o returns one beat per pop with the event byte and
//   an empty flag. Scan samples return nothing.
// press_mark is written through press_mark_we_i / press_mark_i; the user must
//   do so only while idle, as the block itself does not enforce it.
// A pop's result passes through the command queue and then the result register.
// Throughput: one request per cycle while the command queue has room; each scan
//   updates all rows of its column together, pushing presses in row order.
// A two-entry command queue parts the front from the back, so requests keep
//   flowing while a result waits; when rsp_o stalls, pops back up in that
//   queue and req_i.ready falls once it holds two commands.
// Reset clears all key histories, both slots and pointers and the result valid
//   flag, but not the result payload, and sets press_mark to 1.
// Depends on khq_pkg, khq_if, khq_front, khq_cmd_fifo, khq_back and the macro header.
`timescale 1ns / 1ps
`include "keypad_history_event_queue_macros.svh"

module keypad_history_event_queue #(
  parameter int unsigned ROW_COUNT    = 4,
  parameter int unsigned KEY_COUNT    = 16,
  parameter int unsigned HISTORY_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      press_mark_we_i,
  input  logic      press_mark_i,
  khq_in_if.sink    req_i,
  khq_out_if.source rsp_o
);
  import khq_pkg::*;

  localparam int unsigned QW = $bits(cmd_t) + ROW_COUNT;

  logic                 front_valid;
  cmd_t                 front_cmd;
  logic [ROW_COUNT-1:0] front_ok;
  logic                 fifo_full;
  logic                 fifo_empty;
  logic                 fifo_push;
  logic                 fifo_pop;
  logic [QW-1:0]        fifo_head;
  cmd_t                 back_cmd;
  logic [ROW_COUNT-1:0] back_ok;
  logic                 back_ready;

  // Classify incoming beats
  khq_front #(
    .ROW_COUNT (ROW_COUNT),
    .KEY_COUNT (KEY_COUNT)
  ) u_front (
    .req_i       (req_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (!fifo_full),
    .cmd_o       (front_cmd),
    .key_ok_o    (front_ok)
  );

  assign fifo_push = front_valid && !fifo_full;
  assign fifo_pop  = !fifo_empty && back_ready;

  // Queue commands between front and back
  khq_cmd_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i ({front_cmd, front_ok}),
    .full_o      (fifo_full),
    .pop_i       (fifo_pop),
    .empty_o     (fifo_empty),
    .head_o      (fifo_head)
  );

  assign {back_cmd, back_ok} = fifo_head;

  // Carry out scans and pops
  khq_back #(
    .ROW_COUNT    (ROW_COUNT),
    .HISTORY_BITS (HISTORY_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .press_mark_we_i (press_mark_we_i),
    .press_mark_i    (press_mark_i),
    .cmd_valid_i     (!fifo_empty),
    .cmd_i           (back_cmd),
    .key_ok_i        (back_ok),
    .cmd_ready_o     (back_ready),
    .rsp_o           (rsp_o)
  );

  // Check queue and result behaviour
  `KHQ_ASSERT_IMP(a_empty_means_zero, rsp_o.valid,
                  rsp_o.queue_empty == (rsp_o.event_code == '0),
                  "empty flag disagrees with event code")
  `KHQ_ASSERT_IMP(a_pop_waits_for_slot,
                  fifo_pop && back_cmd.op == OP_POP && rsp_o.valid, rsp_o.ready,
                  "pop executed while result register still held")
  `KHQ_ASSERT_NXT(a_accept_fills_queue, req_i.valid && req_i.ready, !fifo_empty,
                  "accepted beat missing from command queue")

endmodule
